### src/tpa_pkg.sv
`timescale 1ns / 1ps

package tpa_pkg;

  localparam int ERFC_TABLE_SIZE_DEF = 512;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_POINT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPI_CONST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPI_SLOPE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THERM_CONST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THERM_INV_SLOPE = 3'd5;

  localparam logic signed [31:0] MIX_WIDTH_RST   = 32'sd65536;
  localparam logic signed [31:0] CROSS_POINT_RST = 32'sd65536;

  localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

  // erfc entries and weights in q16 / q17
  localparam int E_W = 18;
  localparam logic [E_W-1:0] N_ONE_Q17 = 18'd131072;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_D_RANGE = 2'd1,
    ERR_ARITH   = 2'd2
  } err_t;

  typedef struct packed {
    logic valid;
    logic last;
    err_t err;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] alpha;
    err_t               err;
    logic               last;
  } res_t;

  // table build helpers, evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mulq36(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[99:36];
  endfunction

  function automatic logic [E_W-1:0] erfc_point(input logic [63:0] x, input logic neg);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] ps;
    logic [63:0] ng;
    logic [63:0] s;
    logic [63:0] erf;
    logic [63:0] v;
    logic [63:0] one;
    logic [63:0] vr;
    one = 64'd1 << 36;
    x2 = mulq36(x, x);
    p = x;
    ps = x;
    ng = '0;
    for (int k = 1; k < 200; k++) begin
      p = udiv64(mulq36(p, x2), 64'(k));
      if (p == 64'd0) break;
      if (k % 2 == 1) ng = ng + udiv64(p, 64'(2 * k + 1));
      else ps = ps + udiv64(p, 64'(2 * k + 1));
    end
    s = (ps > ng) ? ps - ng : 64'd0;
    erf = mulq36(s, 64'd77541625923);
    if (erf > one) erf = one;
    v = neg ? one + erf : one - erf;
    vr = (v + (64'd1 << 19)) >> 20;
    return vr[E_W-1:0];
  endfunction

  // entry i of a table spread evenly over [-4, 4] with m intervals
  function automatic logic [E_W-1:0] erfc_entry(input int i, input int m);
    longint off;
    logic [63:0] mag;
    logic [63:0] x;
    off = 64'(8 * i) - 64'(4 * m);
    mag = (off < 0) ? 64'(-off) : 64'(off);
    x = udiv64(mag << 36, 64'(m));
    return erfc_point(x, off < 0);
  endfunction

endpackage

### src/tpa_div_pipe.sv
`timescale 1ns / 1ps

module tpa_div_pipe #(
  parameter int QW = 48,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // one quotient bit per stage, msb first
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] num_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [QW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] quo_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = num;
      assign den_p = den;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign num_p = num_r[k-1];
      assign den_p = den_r[k-1];
      assign quo_p = quo_r[k-1];
    end

    assign trial = {rem_p, num_p[QW-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_r[k] <= {num_p[QW-2:0], 1'b0};
        den_r[k] <= den_p;
        quo_r[k] <= {quo_p[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

### src/tpa_erfc_interp.sv
`timescale 1ns / 1ps

module tpa_erfc_interp #(
  parameter int TBL_SIZE = tpa_pkg::ERFC_TABLE_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [19:0]              u,
  output logic [tpa_pkg::E_W-1:0]  e
);
  import tpa_pkg::*;

  localparam int IDXW = $clog2(TBL_SIZE);
  localparam int EVN  = (TBL_SIZE + 1) / 2;
  localparam int ODN  = TBL_SIZE / 2;
  localparam int EAW  = $clog2(EVN);
  localparam int OAW  = $clog2(ODN);
  localparam int PW   = 20 + IDXW;
  localparam logic [IDXW:0]   IDX_TOP = (IDXW+1)'(TBL_SIZE - 2);
  localparam logic [IDXW-1:0] M1      = IDXW'(TBL_SIZE - 1);

  // even and odd entries in separate banks so idx and idx+1 hit one of each
  logic [E_W-1:0] rom_even [EVN];
  logic [E_W-1:0] rom_odd  [ODN];

  for (genvar i = 0; i < EVN; i++) begin : g_even
    localparam logic [E_W-1:0] ENT = erfc_entry(2 * i, TBL_SIZE - 1);
    assign rom_even[i] = ENT;
  end
  for (genvar i = 0; i < ODN; i++) begin : g_odd
    localparam logic [E_W-1:0] ENT = erfc_entry(2 * i + 1, TBL_SIZE - 1);
    assign rom_odd[i] = ENT;
  end

  logic [PW-1:0]   pos;
  logic [IDXW:0]   idx_raw;
  logic [IDXW-1:0] f_idx_r;
  logic [20:0]     f_frac_r;
  logic [IDXW:0]   idx_inc;
  logic [EAW-1:0]  even_addr;
  logic [OAW-1:0]  odd_addr;
  logic [E_W-1:0]  g_even_r;
  logic [E_W-1:0]  g_odd_r;
  logic            g_lsb_r;
  logic [20:0]     g_frac_r;
  logic [E_W-1:0]  r0;
  logic [E_W-1:0]  r1;
  logic signed [E_W:0]  dlt;
  logic signed [39:0]   h_prod_r;
  logic [E_W-1:0]       h_base_r;
  logic signed [40:0]   blend;
  logic signed [40:0]   blend_rnd;
  logic [E_W-1:0]       e_r;

  assign pos     = PW'(u) * PW'(M1);
  assign idx_raw = pos[PW-1:19];

  always_ff @(posedge clk) begin
    if (en) begin
      // top of the range lands exactly on the last entry
      if (idx_raw > IDX_TOP) begin
        f_idx_r  <= IDX_TOP[IDXW-1:0];
        f_frac_r <= 21'd524288;
      end else begin
        f_idx_r  <= idx_raw[IDXW-1:0];
        f_frac_r <= {2'b00, pos[18:0]};
      end
    end
  end

  assign idx_inc   = {1'b0, f_idx_r} + (IDXW+1)'(1);
  assign even_addr = idx_inc[EAW:1];
  assign odd_addr  = f_idx_r[OAW:1];

  always_ff @(posedge clk) begin
    if (en) begin
      g_even_r <= rom_even[even_addr];
      g_odd_r  <= rom_odd[odd_addr];
      g_lsb_r  <= f_idx_r[0];
      g_frac_r <= f_frac_r;
    end
  end

  assign r0  = g_lsb_r ? g_odd_r  : g_even_r;
  assign r1  = g_lsb_r ? g_even_r : g_odd_r;
  assign dlt = $signed({1'b0, r1}) - $signed({1'b0, r0});

  always_ff @(posedge clk) begin
    if (en) begin
      h_prod_r <= 40'(dlt) * 40'($signed(g_frac_r));
      h_base_r <= r0;
    end
  end

  assign blend     = $signed({4'b0000, h_base_r, 19'd0}) + 41'(h_prod_r);
  assign blend_rnd = blend + 41'sd262144;

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= blend_rnd[36:19];
    end
  end

  assign e = e_r;

endmodule

### src/tpa_out_buf.sv
`timescale 1ns / 1ps

module tpa_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpa_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output tpa_pkg::res_t out_data
);
  import tpa_pkg::*;

  logic [1:0] cnt_r;
  res_t       slot0_r;
  res_t       slot1_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign out_data  = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) slot0_r <= slot1_r;
      else if (push) slot0_r <= push_data;
      if (push && cnt_r == 2'd2) slot1_r <= push_data;
    end else if (push) begin
      if (cnt_r == 2'd0) slot0_r <= push_data;
      else slot1_r <= push_data;
    end
  end

endmodule

### src/tof_profile_alpha_eval.sv
// throughput: one word per cycle while the output buffer is not full
// the three long divisions are bit-per-stage pipelines
// a two-word output buffer keeps the input open while a result waits
// reset (synchronous, rst_n low) empties the pipeline and buffer and loads register defaults
// the erfc table is constant logic, so no clearing pass is needed after reset
`timescale 1ns / 1ps

module tof_profile_alpha_eval #(
  parameter int ERFC_TABLE_SIZE = tpa_pkg::ERFC_TABLE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_d_spacing,
  input  logic                            in_last_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_alpha_value,
  output logic [1:0]                      out_error_code,
  output logic                            out_last_out,
  input  logic                            cfg_we,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import tpa_pkg::*;

  localparam int D1_QW = 48;
  localparam int D1_DW = 31;
  localparam int D3_QW = 50;
  localparam int D3_DW = 49;
  localparam int EF_LAT = 4;
  localparam logic signed [49:0] LIM_HI = 50'sd2147483647;
  localparam logic signed [49:0] LIM_LO = -50'sd2147483648;

  logic signed [31:0] mix_width_r;
  logic signed [31:0] cross_point_r;
  logic signed [31:0] epi_const_r;
  logic signed [31:0] epi_slope_r;
  logic signed [31:0] therm_const_r;
  logic signed [31:0] therm_inv_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_width_r       <= MIX_WIDTH_RST;
      cross_point_r     <= CROSS_POINT_RST;
      epi_const_r       <= '0;
      epi_slope_r       <= '0;
      therm_const_r     <= '0;
      therm_inv_slope_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIX_WIDTH:       mix_width_r       <= cfg_wdata;
        REG_CROSS_POINT:     cross_point_r     <= cfg_wdata;
        REG_EPI_CONST:       epi_const_r       <= cfg_wdata;
        REG_EPI_SLOPE:       epi_slope_r       <= cfg_wdata;
        REG_THERM_CONST:     therm_const_r     <= cfg_wdata;
        REG_THERM_INV_SLOPE: therm_inv_slope_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic buf_full;
  assign en       = !buf_full;
  assign in_ready = en;

  // ---------------- control path (valid, last, error) ----------------
  ctl_t a_ctl_r;
  ctl_t dl_ctl_r [D1_QW];
  ctl_t c_ctl_r;
  ctl_t d_ctl_r;
  ctl_t e_ctl_r;
  ctl_t s_ctl_r [EF_LAT];
  ctl_t j_ctl_r;
  ctl_t k_ctl_r;
  ctl_t l_ctl_r;
  ctl_t dl3_ctl_r [D3_QW];

  // ---------------- data path ----------------
  logic signed [31:0] a_d_r;
  logic signed [63:0] dl_tap_r [D1_QW];
  logic signed [33:0] c_diff_r;
  logic signed [49:0] c_ta_r;
  logic signed [49:0] c_tt_r;
  logic [64:0]        d_prod_r;
  logic               d_zneg_r;
  logic signed [31:0] d_ta_r;
  logic signed [31:0] d_tt_r;
  logic [19:0]        e_u_r;
  logic signed [31:0] e_ta_r;
  logic signed [31:0] e_tt_r;
  logic signed [31:0] s_ta_r [EF_LAT];
  logic signed [31:0] s_tt_r [EF_LAT];
  logic signed [50:0] j_m1_r;
  logic signed [50:0] j_m2_r;
  logic signed [50:0] k_den_r;
  logic [D3_DW-1:0]   l_dm_r;
  logic [D3_QW-1:0]   l_num_r;
  logic               l_neg_r;
  logic               dl3_neg_r [D3_QW];

  ctl_t a_ctl_nxt;
  ctl_t d_ctl_nxt;
  ctl_t l_ctl_nxt;

  // stage a: input register
  assign a_ctl_nxt.valid = in_valid;
  assign a_ctl_nxt.last  = in_last_in;
  assign a_ctl_nxt.err   = (in_d_spacing <= 32'sd0) ? ERR_D_RANGE : ERR_OK;

  // dividers for 1/d and therm_inv_slope/d, both rounded
  logic [30:0]       d_pos;
  logic [31:0]       a1t_mag;
  logic [D1_QW-1:0]  div1_num;
  logic [D1_QW-1:0]  div2_num;
  logic [D1_QW-1:0]  div1_quo;
  logic [D1_QW-1:0]  div2_quo;
  logic [32:0]       a1t_neg;

  assign d_pos    = a_d_r[30:0];
  assign a1t_neg  = -{therm_inv_slope_r[31], therm_inv_slope_r};
  assign a1t_mag  = therm_inv_slope_r[31] ? a1t_neg[31:0] : therm_inv_slope_r;
  assign div1_num = (D1_QW'(1) << 32) + D1_QW'(d_pos >> 1);
  assign div2_num = {a1t_mag, 16'd0} + D1_QW'(d_pos >> 1);

  tpa_div_pipe #(.QW(D1_QW), .DW(D1_DW)) u_div_inv (
    .clk (clk),
    .en  (en),
    .num (div1_num),
    .den (d_pos),
    .quo (div1_quo)
  );

  tpa_div_pipe #(.QW(D1_QW), .DW(D1_DW)) u_div_therm (
    .clk (clk),
    .en  (en),
    .num (div2_num),
    .den (d_pos),
    .quo (div2_quo)
  );

  // stage c: 1/d difference, epithermal and thermal terms
  logic signed [63:0] tap;
  logic [63:0]        tap_mag;
  logic [63:0]        tap_rnd;
  logic signed [49:0] ta_part;
  logic signed [49:0] tt_part;
  logic signed [49:0] ta_sum;
  logic signed [49:0] tt_sum;

  assign tap     = dl_tap_r[D1_QW-1];
  assign tap_mag = tap[63] ? 64'(-tap) : 64'(tap);
  assign tap_rnd = tap_mag + 64'd32768;
  assign ta_part = tap[63] ? -$signed({2'b00, tap_rnd[63:16]}) : $signed({2'b00, tap_rnd[63:16]});
  assign tt_part = therm_inv_slope_r[31] ? -$signed({2'b00, div2_quo})
                                         : $signed({2'b00, div2_quo});
  assign ta_sum  = 50'(epi_const_r) + ta_part;
  assign tt_sum  = 50'(therm_const_r) - tt_part;

  // stage d: z magnitude product and term range check
  logic [32:0] w_neg;
  logic [31:0] w_mag;
  logic signed [33:0] diff_neg;
  logic [32:0] diff_mag;
  logic        term_ovf;

  assign w_neg    = -{mix_width_r[31], mix_width_r};
  assign w_mag    = mix_width_r[31] ? w_neg[31:0] : mix_width_r;
  assign diff_neg = -c_diff_r;
  assign diff_mag = c_diff_r[33] ? diff_neg[32:0] : c_diff_r[32:0];
  assign term_ovf = (c_ta_r > LIM_HI) || (c_ta_r < LIM_LO) ||
                    (c_tt_r > LIM_HI) || (c_tt_r < LIM_LO);

  always_comb begin
    d_ctl_nxt = c_ctl_r;
    if (c_ctl_r.err == ERR_OK && term_ovf) d_ctl_nxt.err = ERR_ARITH;
  end

  // stage e: round, clamp to +-4 and offset into table coordinates
  logic [64:0] z_rnd;
  logic [48:0] z_mag;
  logic [19:0] z_clamp;

  assign z_rnd   = d_prod_r + 65'd32768;
  assign z_mag   = z_rnd[64:16];
  assign z_clamp = (z_mag > 49'd262144) ? 20'd262144 : z_mag[19:0];

  logic [E_W-1:0] e_val;

  tpa_erfc_interp #(.TBL_SIZE(ERFC_TABLE_SIZE)) u_erfc (
    .clk (clk),
    .en  (en),
    .u   (e_u_r),
    .e   (e_val)
  );

  // stage l: magnitude of the denominator and rounded dividend for 2^49/den
  logic [50:0] den_abs;
  assign den_abs = k_den_r[50] ? 51'(-k_den_r) : 51'(k_den_r);

  always_comb begin
    l_ctl_nxt = k_ctl_r;
    if (k_ctl_r.err == ERR_OK && k_den_r == 51'sd0) l_ctl_nxt.err = ERR_ARITH;
  end

  logic [D3_QW-1:0] div3_quo;

  tpa_div_pipe #(.QW(D3_QW), .DW(D3_DW)) u_div_alpha (
    .clk (clk),
    .en  (en),
    .num (l_num_r),
    .den (l_dm_r),
    .quo (div3_quo)
  );

  // final stage: saturation into the output buffer
  ctl_t m_ctl;
  logic m_neg;
  res_t m_res;
  logic push;

  assign m_ctl = dl3_ctl_r[D3_QW-1];
  assign m_neg = dl3_neg_r[D3_QW-1];
  assign push  = en && m_ctl.valid;

  always_comb begin
    m_res.last  = m_ctl.last;
    m_res.err   = m_ctl.err;
    m_res.alpha = SAT_POS;
    if (m_ctl.err == ERR_OK) begin
      if (!m_neg) begin
        if (div3_quo > D3_QW'(SAT_POS)) m_res.err = ERR_ARITH;
        else m_res.alpha = div3_quo[31:0];
      end else begin
        if (div3_quo > (D3_QW'(1) << 31)) begin
          m_res.err   = ERR_ARITH;
          m_res.alpha = SAT_NEG;
        end else begin
          m_res.alpha = -$signed(div3_quo[31:0]);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      c_ctl_r <= '0;
      d_ctl_r <= '0;
      e_ctl_r <= '0;
      j_ctl_r <= '0;
      k_ctl_r <= '0;
      l_ctl_r <= '0;
      for (int i = 0; i < D1_QW; i++) dl_ctl_r[i] <= '0;
      for (int i = 0; i < EF_LAT; i++) s_ctl_r[i] <= '0;
      for (int i = 0; i < D3_QW; i++) dl3_ctl_r[i] <= '0;
    end else if (en) begin
      a_ctl_r     <= a_ctl_nxt;
      dl_ctl_r[0] <= a_ctl_r;
      for (int i = 1; i < D1_QW; i++) dl_ctl_r[i] <= dl_ctl_r[i-1];
      c_ctl_r     <= dl_ctl_r[D1_QW-1];
      d_ctl_r     <= d_ctl_nxt;
      e_ctl_r     <= d_ctl_r;
      s_ctl_r[0]  <= e_ctl_r;
      for (int i = 1; i < EF_LAT; i++) s_ctl_r[i] <= s_ctl_r[i-1];
      j_ctl_r     <= s_ctl_r[EF_LAT-1];
      k_ctl_r     <= j_ctl_r;
      l_ctl_r     <= l_ctl_nxt;
      dl3_ctl_r[0] <= l_ctl_r;
      for (int i = 1; i < D3_QW; i++) dl3_ctl_r[i] <= dl3_ctl_r[i-1];
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r       <= in_d_spacing;
      dl_tap_r[0] <= epi_slope_r * a_d_r;
      for (int i = 1; i < D1_QW; i++) dl_tap_r[i] <= dl_tap_r[i-1];

      c_diff_r <= 34'(cross_point_r) - $signed({1'b0, div1_quo[32:0]});
      c_ta_r   <= ta_sum;
      c_tt_r   <= tt_sum;

      d_prod_r <= 65'(w_mag) * 65'(diff_mag);
      d_zneg_r <= mix_width_r[31] ^ c_diff_r[33];
      d_ta_r   <= c_ta_r[31:0];
      d_tt_r   <= c_tt_r[31:0];

      e_u_r  <= d_zneg_r ? 20'd262144 - z_clamp : 20'd262144 + z_clamp;
      e_ta_r <= d_ta_r;
      e_tt_r <= d_tt_r;

      s_ta_r[0] <= e_ta_r;
      s_tt_r[0] <= e_tt_r;
      for (int i = 1; i < EF_LAT; i++) begin
        s_ta_r[i] <= s_ta_r[i-1];
        s_tt_r[i] <= s_tt_r[i-1];
      end

      // weights e and (1-n) share q17
      j_m1_r <= 51'($signed({1'b0, e_val})) * 51'(s_ta_r[EF_LAT-1]);
      j_m2_r <= 51'($signed({1'b0, N_ONE_Q17 - e_val})) * 51'(s_tt_r[EF_LAT-1]);

      k_den_r <= j_m1_r + j_m2_r;

      l_dm_r  <= den_abs[D3_DW-1:0];
      l_num_r <= (D3_QW'(1) << 49) + D3_QW'(den_abs[D3_DW-1:0] >> 1);
      l_neg_r <= k_den_r[50];

      dl3_neg_r[0] <= l_neg_r;
      for (int i = 1; i < D3_QW; i++) dl3_neg_r[i] <= dl3_neg_r[i-1];
    end
  end

  res_t out_word;

  tpa_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (m_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_word)
  );

  assign out_alpha_value = out_word.alpha;
  assign out_error_code  = out_word.err;
  assign out_last_out    = out_word.last;

  // a stalled input always means a word is waiting at the output
  a_in_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no word waiting");

  a_err_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == ERR_OK || out_error_code == ERR_D_RANGE ||
                   out_error_code == ERR_ARITH))
    else $error("unused error code on output");

  a_d_range_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code == ERR_D_RANGE) |-> out_alpha_value == SAT_POS)
    else $error("bad d without positive saturation");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> !push)
    else $error("result pushed into full buffer");

endmodule
